// ===== hdl/hsl2rgb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the HSL to RGB converter.
// No dependencies; used by every module of the block by scoped names.
package hsl2rgb_pkg;

    // Input field widths
    localparam int HUE_W   = 9;
    localparam int PCT_W   = 7;
    localparam int CHAN_W  = 8;

    // Fixed point: one unit is 1/600000 of full scale
    localparam int VAL_W       = 20;
    localparam int FULL_SCALE  = 600000;
    localparam int CHROMA_W    = 14;     // (100 - |2L-100|) * S, up to 10000
    localparam int FRAC_W      = 6;      // 60 - |(H mod 120) - 60|, up to 60

    localparam int PCT_MAX     = 100;
    localparam int HUE_WRAP    = 360;
    localparam int SECTOR_DEG  = 60;
    localparam int LIGHT_UNIT  = 6000;   // FULL_SCALE / 100
    localparam int HALF_SECTOR = 30;     // c/2 = chroma * 30

    // floor(s * 255 / 600000) = floor(s * 17 / 40000)
    // t = s * 17 < 2^24; ceil(2^39 / 40000) gives an exact quotient over that range.
    localparam int T_W         = 24;
    localparam int RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] RECIP = 24'd13743896;
    localparam int RECIP_SHIFT = 39;
    localparam int PROD_W      = T_W + RECIP_W;

    // 60-degree hue sectors
    typedef enum logic [2:0] {
        SEC_RED_YEL  = 3'd0,
        SEC_YEL_GRN  = 3'd1,
        SEC_GRN_CYN  = 3'd2,
        SEC_CYN_BLU  = 3'd3,
        SEC_BLU_MAG  = 3'd4,
        SEC_MAG_RED  = 3'd5
    } sector_t;

    // Chroma, secondary and offset of one pixel
    typedef struct packed {
        sector_t              sector;
        logic [VAL_W-1:0]     c;
        logic [VAL_W-1:0]     x;
        logic [VAL_W-1:0]     m;
    } cxm_t;

    // Channel order inside lane arrays
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int NUM_CH   = 3;

endpackage

// ===== hdl/hsl2rgb_front.sv =====
`timescale 1ns / 1ps
// Front end: input clamping, hue sector, chroma, secondary and offset.
// Three elastic register stages. Depends on hsl2rgb_pkg.
module hsl2rgb_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [hsl2rgb_pkg::HUE_W-1:0]      hue_deg,
    input  logic [hsl2rgb_pkg::PCT_W-1:0]      sat_pct,
    input  logic [hsl2rgb_pkg::PCT_W-1:0]      light_pct,
    output logic                               out_valid,
    input  logic                               out_ready,
    output hsl2rgb_pkg::cxm_t                  out_cxm
);

    // stage enables
    logic en1, en2, en3;

    // stage 1
    logic                                v1_reg, v1_next;
    hsl2rgb_pkg::sector_t                sector1_reg, sector1_next;
    logic [hsl2rgb_pkg::FRAC_W-1:0]      frac1_reg, frac1_next;
    logic [hsl2rgb_pkg::PCT_W-1:0]       k1_reg, k1_next;
    logic [hsl2rgb_pkg::PCT_W-1:0]       sat1_reg, sat1_next;
    logic [hsl2rgb_pkg::PCT_W-1:0]       light1_reg, light1_next;

    // stage 2
    logic                                v2_reg, v2_next;
    hsl2rgb_pkg::sector_t                sector2_reg;
    logic [hsl2rgb_pkg::FRAC_W-1:0]      frac2_reg;
    logic [hsl2rgb_pkg::PCT_W-1:0]       light2_reg;
    logic [hsl2rgb_pkg::CHROMA_W-1:0]    cn2_reg, cn2_next;

    // stage 3
    logic                                v3_reg, v3_next;
    hsl2rgb_pkg::cxm_t                   cxm3_reg, cxm3_next;

    // stage 1 working values
    logic [hsl2rgb_pkg::HUE_W-1:0]       hue_w;
    logic [hsl2rgb_pkg::HUE_W-1:0]       hue_base;
    logic [hsl2rgb_pkg::PCT_W-1:0]       hue_mod;
    logic [hsl2rgb_pkg::FRAC_W-1:0]      hue_dist;
    logic [hsl2rgb_pkg::PCT_W:0]         light2x;
    logic [hsl2rgb_pkg::PCT_W:0]         light_dist;

    assign en3 = !v3_reg || out_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    assign v1_next = en1 ? in_valid : v1_reg;
    assign v2_next = en2 ? v1_reg   : v2_reg;
    assign v3_next = en3 ? v2_reg   : v3_reg;

    // stage 1: wrap hue, clamp percentages, sector and triangle fraction
    always_comb begin
        hue_w = (hue_deg >= 9'(hsl2rgb_pkg::HUE_WRAP))
              ? hue_deg - 9'(hsl2rgb_pkg::HUE_WRAP) : hue_deg;

        priority if (hue_w < 9'(hsl2rgb_pkg::SECTOR_DEG)) begin
            sector1_next = hsl2rgb_pkg::SEC_RED_YEL;
            hue_base     = 9'd0;
        end else if (hue_w < 9'(2 * hsl2rgb_pkg::SECTOR_DEG)) begin
            sector1_next = hsl2rgb_pkg::SEC_YEL_GRN;
            hue_base     = 9'd0;
        end else if (hue_w < 9'(3 * hsl2rgb_pkg::SECTOR_DEG)) begin
            sector1_next = hsl2rgb_pkg::SEC_GRN_CYN;
            hue_base     = 9'(2 * hsl2rgb_pkg::SECTOR_DEG);
        end else if (hue_w < 9'(4 * hsl2rgb_pkg::SECTOR_DEG)) begin
            sector1_next = hsl2rgb_pkg::SEC_CYN_BLU;
            hue_base     = 9'(2 * hsl2rgb_pkg::SECTOR_DEG);
        end else if (hue_w < 9'(5 * hsl2rgb_pkg::SECTOR_DEG)) begin
            sector1_next = hsl2rgb_pkg::SEC_BLU_MAG;
            hue_base     = 9'(4 * hsl2rgb_pkg::SECTOR_DEG);
        end else begin
            sector1_next = hsl2rgb_pkg::SEC_MAG_RED;
            hue_base     = 9'(4 * hsl2rgb_pkg::SECTOR_DEG);
        end

        // hue mod 120, then 60 - |hm - 60|
        hue_mod  = 7'(hue_w - hue_base);
        hue_dist = (hue_mod >= 7'(hsl2rgb_pkg::SECTOR_DEG))
                 ? 6'(hue_mod - 7'(hsl2rgb_pkg::SECTOR_DEG))
                 : 6'(7'(hsl2rgb_pkg::SECTOR_DEG) - hue_mod);
        frac1_next = 6'(hsl2rgb_pkg::SECTOR_DEG) - hue_dist;

        sat1_next   = (sat_pct > 7'(hsl2rgb_pkg::PCT_MAX))
                    ? 7'(hsl2rgb_pkg::PCT_MAX) : sat_pct;
        light1_next = (light_pct > 7'(hsl2rgb_pkg::PCT_MAX))
                    ? 7'(hsl2rgb_pkg::PCT_MAX) : light_pct;

        // 100 - |2L - 100|
        light2x    = {light1_next, 1'b0};
        light_dist = (light2x >= 8'(hsl2rgb_pkg::PCT_MAX))
                   ? light2x - 8'(hsl2rgb_pkg::PCT_MAX)
                   : 8'(hsl2rgb_pkg::PCT_MAX) - light2x;
        k1_next    = 7'(8'(hsl2rgb_pkg::PCT_MAX) - light_dist);
    end

    // stage 2: chroma numerator
    assign cn2_next = 14'(k1_reg) * 14'(sat1_reg);

    // stage 3: c, x and m in 1/600000 units
    always_comb begin
        cxm3_next.sector = sector2_reg;
        cxm3_next.c = 20'(cn2_reg) * 20'(hsl2rgb_pkg::SECTOR_DEG);
        cxm3_next.x = 20'(cn2_reg) * 20'(frac2_reg);
        cxm3_next.m = 20'(light2_reg) * 20'(hsl2rgb_pkg::LIGHT_UNIT)
                    - 20'(cn2_reg) * 20'(hsl2rgb_pkg::HALF_SECTOR);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            sector1_reg <= sector1_next;
            frac1_reg   <= frac1_next;
            k1_reg      <= k1_next;
            sat1_reg    <= sat1_next;
            light1_reg  <= light1_next;
        end
        if (en2) begin
            sector2_reg <= sector1_reg;
            frac2_reg   <= frac1_reg;
            light2_reg  <= light1_reg;
            cn2_reg     <= cn2_next;
        end
        if (en3) begin
            cxm3_reg    <= cxm3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_cxm   = cxm3_reg;

    // secondary never exceeds chroma
    a_x_within_c: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (cxm3_reg.x <= cxm3_reg.c))
        else $error("secondary above chroma");

    // primary channel plus offset stays within full scale
    a_c_plus_m: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> ((21'(cxm3_reg.c) + 21'(cxm3_reg.m)) <= 21'(hsl2rgb_pkg::FULL_SCALE)))
        else $error("chroma plus offset beyond full scale");

endmodule

// ===== hdl/hsl2rgb_back.sv =====
`timescale 1ns / 1ps
// Back end: channel placement by sector, scaling to 0..255 via reciprocal multiply.
// Three elastic register stages, one lane per channel. Depends on hsl2rgb_pkg.
module hsl2rgb_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  hsl2rgb_pkg::cxm_t                  in_cxm,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [hsl2rgb_pkg::CHAN_W-1:0]     red,
    output logic [hsl2rgb_pkg::CHAN_W-1:0]     green,
    output logic [hsl2rgb_pkg::CHAN_W-1:0]     blue
);

    logic en4, en5, en6;
    logic v4_reg, v4_next;
    logic v5_reg, v5_next;
    logic v6_reg, v6_next;

    logic [hsl2rgb_pkg::VAL_W-1:0]   vsel [hsl2rgb_pkg::NUM_CH];
    logic [hsl2rgb_pkg::VAL_W-1:0]   vsum [hsl2rgb_pkg::NUM_CH];
    logic [hsl2rgb_pkg::T_W-1:0]     t4_reg  [hsl2rgb_pkg::NUM_CH];
    logic [hsl2rgb_pkg::T_W-1:0]     t4_next [hsl2rgb_pkg::NUM_CH];
    logic [hsl2rgb_pkg::PROD_W-1:0]  p5_reg  [hsl2rgb_pkg::NUM_CH];
    logic [hsl2rgb_pkg::PROD_W-1:0]  p5_next [hsl2rgb_pkg::NUM_CH];
    logic [hsl2rgb_pkg::CHAN_W-1:0]  q6_reg  [hsl2rgb_pkg::NUM_CH];
    logic [hsl2rgb_pkg::CHAN_W-1:0]  q6_next [hsl2rgb_pkg::NUM_CH];

    assign en6 = !v6_reg || out_ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign in_ready = en4;

    assign v4_next = en4 ? in_valid : v4_reg;
    assign v5_next = en5 ? v4_reg   : v5_reg;
    assign v6_next = en6 ? v5_reg   : v6_reg;

    // stage 4: place c, x, 0 by sector
    always_comb begin
        unique case (in_cxm.sector)
            hsl2rgb_pkg::SEC_RED_YEL: begin
                vsel[hsl2rgb_pkg::CH_RED]   = in_cxm.c;
                vsel[hsl2rgb_pkg::CH_GREEN] = in_cxm.x;
                vsel[hsl2rgb_pkg::CH_BLUE]  = '0;
            end
            hsl2rgb_pkg::SEC_YEL_GRN: begin
                vsel[hsl2rgb_pkg::CH_RED]   = in_cxm.x;
                vsel[hsl2rgb_pkg::CH_GREEN] = in_cxm.c;
                vsel[hsl2rgb_pkg::CH_BLUE]  = '0;
            end
            hsl2rgb_pkg::SEC_GRN_CYN: begin
                vsel[hsl2rgb_pkg::CH_RED]   = '0;
                vsel[hsl2rgb_pkg::CH_GREEN] = in_cxm.c;
                vsel[hsl2rgb_pkg::CH_BLUE]  = in_cxm.x;
            end
            hsl2rgb_pkg::SEC_CYN_BLU: begin
                vsel[hsl2rgb_pkg::CH_RED]   = '0;
                vsel[hsl2rgb_pkg::CH_GREEN] = in_cxm.x;
                vsel[hsl2rgb_pkg::CH_BLUE]  = in_cxm.c;
            end
            hsl2rgb_pkg::SEC_BLU_MAG: begin
                vsel[hsl2rgb_pkg::CH_RED]   = in_cxm.x;
                vsel[hsl2rgb_pkg::CH_GREEN] = '0;
                vsel[hsl2rgb_pkg::CH_BLUE]  = in_cxm.c;
            end
            default: begin
                vsel[hsl2rgb_pkg::CH_RED]   = in_cxm.c;
                vsel[hsl2rgb_pkg::CH_GREEN] = '0;
                vsel[hsl2rgb_pkg::CH_BLUE]  = in_cxm.x;
            end
        endcase
    end

    // per lane: (v + m) * 17, then * recip, then take the quotient bits
    always_comb begin
        for (int i = 0; i < hsl2rgb_pkg::NUM_CH; i++) begin
            vsum[i]    = vsel[i] + in_cxm.m;
            t4_next[i] = {vsum[i], 4'b0000} + 24'(vsum[i]);
            p5_next[i] = 48'(t4_reg[i]) * 48'(hsl2rgb_pkg::RECIP);
            q6_next[i] = p5_reg[i][hsl2rgb_pkg::RECIP_SHIFT +: hsl2rgb_pkg::CHAN_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            v4_reg <= v4_next;
            v5_reg <= v5_next;
            v6_reg <= v6_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < hsl2rgb_pkg::NUM_CH; i++) begin
            if (en4) begin
                t4_reg[i] <= t4_next[i];
            end
            if (en5) begin
                p5_reg[i] <= p5_next[i];
            end
            if (en6) begin
                q6_reg[i] <= q6_next[i];
            end
        end
    end

    assign out_valid = v6_reg;
    assign red   = q6_reg[hsl2rgb_pkg::CH_RED];
    assign green = q6_reg[hsl2rgb_pkg::CH_GREEN];
    assign blue  = q6_reg[hsl2rgb_pkg::CH_BLUE];

    // a held product stage keeps its red and blue lanes while the stage after it is full
    a_p5_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v5_reg && !en5) |=> ($stable(p5_reg[hsl2rgb_pkg::CH_RED])
                              && $stable(p5_reg[hsl2rgb_pkg::CH_BLUE]) && v5_reg))
        else $error("product stage lost a stalled beat");

endmodule

// ===== hdl/hsl_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// HSL to RGB converter, six-stage pipeline, one pixel per clock while m_tready is high.
// Top level; depends on hsl2rgb_pkg, hsl2rgb_front and hsl2rgb_back.
//
// Converts hue (degrees), saturation and lightness (percent) to 8-bit RGB,
// each channel exactly floor((v + m) * 255 / 600000) in exact fixed point.
// Hue 360..511 wraps modulo 360; saturation and lightness above 100 clamp to
// 100. Throughput is one beat per clock with no gaps while m_tready is high.
// Six register stages: clamp and sector, chroma multiply, c/x/m, channel sum,
// reciprocal multiply (24x24), quotient register. The pipeline is elastic: a
// stall on m_tready holds each full stage with no empty stage after it, empty
// stages still fill, and s_tready drops only when all six stages hold a beat.
// No configuration; reset only clears the stage valids.
module hsl_to_rgb_converter (
    input  logic        aclk,
    input  logic        aresetn,
    // input pixel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [8:0] hue_deg, [15:9] sat_pct, [22:16] light_pct, [23] zero
    // output colour
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

    logic              mid_valid;
    logic              mid_ready;
    hsl2rgb_pkg::cxm_t mid_cxm;

    logic [hsl2rgb_pkg::CHAN_W-1:0] red;
    logic [hsl2rgb_pkg::CHAN_W-1:0] green;
    logic [hsl2rgb_pkg::CHAN_W-1:0] blue;

    // stages 1..3: clamp, chroma, c/x/m
    hsl2rgb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .hue_deg   (s_tdata[8:0]),
        .sat_pct   (s_tdata[15:9]),
        .light_pct (s_tdata[22:16]),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_cxm   (mid_cxm)
    );

    // stages 4..6: placement and scaling
    hsl2rgb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_cxm    (mid_cxm),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    assign m_tdata = {blue, green, red};

    // a ready sink never throttles the source
    a_flow_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output ready");

    // back-pressure only appears when the output stage is stuck
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && mid_valid))
        else $error("input stalled without a full pipeline");

endmodule

// ===== dv/tb_hsl_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for hsl_to_rgb_converter: a directed table, then random pixels.
// Depends on hsl2rgb_pkg and the RTL of the block only.
module tb_hsl_to_rgb_converter;

    // Package constants used below
    localparam int          HUE_W        = hsl2rgb_pkg::HUE_W;
    localparam int          PCT_W        = hsl2rgb_pkg::PCT_W;
    localparam int          CHAN_W       = hsl2rgb_pkg::CHAN_W;
    localparam int          HUE_WRAP     = hsl2rgb_pkg::HUE_WRAP;
    localparam int          PCT_MAX      = hsl2rgb_pkg::PCT_MAX;
    localparam int          SECTOR_DEG   = hsl2rgb_pkg::SECTOR_DEG;
    localparam int          LIGHT_UNIT   = hsl2rgb_pkg::LIGHT_UNIT;
    localparam int          HALF_SECTOR  = hsl2rgb_pkg::HALF_SECTOR;
    localparam int          FULL_SCALE   = hsl2rgb_pkg::FULL_SCALE;

    localparam int          LATENCY      = 6;        // stages from input beat to output beat
    localparam int          LIMIT_CYCLES = 400000;   // well above the slowest clean run
    localparam int          RANDOM_PIXELS = 1700;
    localparam int          CHUNK        = 100;      // random pixels per idling mode
    localparam int          LONG_HOLD    = 150;      // receiver hold-off, fills the pipeline
    localparam int          MAX_IDLE     = 10;
    localparam int unsigned CHAN_FULL    = (1 << CHAN_W) - 1;

    // Field order matches the bus: hue in the low bits, light at the top
    typedef struct packed {
        logic [PCT_W-1:0] light;
        logic [PCT_W-1:0] sat;
        logic [HUE_W-1:0] hue;
    } hsl_t;

    // Red in the low byte, blue in the high byte
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

    // One row of the directed table; 'known' rows carry a colour typed in by hand
    typedef struct {
        hsl_t px;
        bit   known;
        rgb_t rgb;
    } pixel_row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [8:0] hue_deg, [15:9] sat_pct, [22:16] light_pct, [23] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [7:0] red, [15:8] green, [23:16] blue

    hsl_to_rgb_converter DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Colour that goes with the beat on s_tdata; taken into the queue on its handshake
    rgb_t       offered_colour = '0;
    rgb_t       colour_q[$];
    rgb_t       wanted;
    pixel_row_t pixel_table[$];

    int errors         = 0;
    int colours_seen   = 0;
    int directed_count = 0;
    int random_count   = 0;
    int odd_fields     = 0;   // pixels with a field outside its documented range
    int input_refusals = 0;   // cycles with s_tvalid high and s_tready low
    int longest_hold   = 0;
    int cycles         = 0;

    // Idling knobs, changed by the main sequence between chunks
    int src_max_gap  = MAX_IDLE;
    int snk_max_stall = MAX_IDLE;
    bit hold_request = 1'b0;

    string chan_name [3] = '{"red", "green", "blue"};

    // Expected colour of one pixel, exact fixed point over FULL_SCALE
    function automatic rgb_t hsl_colour(hsl_t px);
        int unsigned          hue, sat, light, chroma, spread, c, x, m;
        int unsigned          lane [3];
        longint unsigned      scaled;
        logic [23:0]          bits;
        hsl2rgb_pkg::sector_t sec;
        hue   = px.hue;
        sat   = px.sat;
        light = px.light;
        // hue wraps past 359, percentages clamp at 100
        if (hue >= HUE_WRAP) hue -= HUE_WRAP;
        if (sat > PCT_MAX) sat = PCT_MAX;
        if (light > PCT_MAX) light = PCT_MAX;
        spread = (2 * light > PCT_MAX) ? 2 * light - PCT_MAX : PCT_MAX - 2 * light;
        chroma = (PCT_MAX - spread) * sat;
        // distance of the hue from the middle of its 120-degree pair of sectors
        spread = hue % (2 * SECTOR_DEG);
        spread = (spread > SECTOR_DEG) ? spread - SECTOR_DEG : SECTOR_DEG - spread;
        c      = chroma * SECTOR_DEG;
        x      = chroma * (SECTOR_DEG - spread);
        m      = light * LIGHT_UNIT - chroma * HALF_SECTOR;
        sec    = hsl2rgb_pkg::sector_t'(hue / SECTOR_DEG);
        unique case (sec)
            hsl2rgb_pkg::SEC_RED_YEL: lane = '{c, x, 0};
            hsl2rgb_pkg::SEC_YEL_GRN: lane = '{x, c, 0};
            hsl2rgb_pkg::SEC_GRN_CYN: lane = '{0, c, x};
            hsl2rgb_pkg::SEC_CYN_BLU: lane = '{0, x, c};
            hsl2rgb_pkg::SEC_BLU_MAG: lane = '{x, 0, c};
            default:                  lane = '{c, 0, x};
        endcase
        for (int i = 0; i < 3; i++) begin
            scaled = (longint'(lane[i] + m) * CHAN_FULL) / FULL_SCALE;
            bits[i*CHAN_W +: CHAN_W] = scaled[CHAN_W-1:0];
        end
        return rgb_t'(bits);
    endfunction

    task automatic add_row(int hue, int sat, int light, bit known, int r, int g, int b);
        pixel_row_t row;
        row.px.hue    = HUE_W'(hue);
        row.px.sat    = PCT_W'(sat);
        row.px.light  = PCT_W'(light);
        row.known     = known;
        row.rgb.red   = CHAN_W'(r);
        row.rgb.green = CHAN_W'(g);
        row.rgb.blue  = CHAN_W'(b);
        pixel_table.push_back(row);
    endtask

    // Offer one pixel from the falling edge and hold it until the block takes it
    task automatic send_pixel(hsl_t px, rgb_t colour);
        int gap;
        gap = (src_max_gap == 0) ? 0 : $urandom_range(0, src_max_gap);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid       <= 1'b1;
        s_tdata        <= {1'b0, px};
        offered_colour <= colour;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random_pixel();
        hsl_t px;
        if ($urandom_range(0, 7) == 0) begin
            // whole field width: wrapped hues and clamped percentages
            px = hsl_t'($urandom);
        end else begin
            px.hue   = HUE_W'($urandom_range(0, HUE_WRAP - 1));
            px.sat   = PCT_W'($urandom_range(0, PCT_MAX));
            px.light = PCT_W'($urandom_range(0, PCT_MAX));
        end
        if (px.hue >= HUE_WRAP || px.sat > PCT_MAX || px.light > PCT_MAX)
            odd_fields++;
        send_pixel(px, hsl_colour(px));
        random_count++;
    endtask

    // Receiver: a fresh stall per output beat, or one long hold-off on request
    initial begin : receiver
        int stall;
        @(posedge aresetn);
        forever begin
            if (hold_request) begin
                stall        = LONG_HOLD;
                hold_request = 1'b0;
            end else begin
                stall = (snk_max_stall == 0) ? 0 : $urandom_range(0, snk_max_stall);
            end
            if (stall > longest_hold) longest_hold = stall;
            @(negedge aclk);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Scoreboard: expectations enter on input beats and leave on output beats
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !s_tready) input_refusals++;
            if (s_tvalid && s_tready) colour_q.push_back(offered_colour);
            if (m_tvalid && m_tready) begin
                colours_seen++;
                if (colour_q.size() == 0) begin
                    $error("output beat 0x%06h with no colour expected", m_tdata);
                    errors++;
                end else begin
                    wanted = colour_q.pop_front();
                    for (int i = 0; i < 3; i++) begin
                        if (m_tdata[i*CHAN_W +: CHAN_W] != wanted[i*CHAN_W +: CHAN_W]) begin
                            $error("%s: expected %0d, got %0d", chan_name[i],
                                   wanted[i*CHAN_W +: CHAN_W], m_tdata[i*CHAN_W +: CHAN_W]);
                            errors++;
                        end
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("tb_hsl_to_rgb_converter: done, errors");
            $finish;
        end
    end

    initial begin : main_sequence
        int drain;
        // corners of the cone; typed colours where they follow at once
        add_row(  0,   0,   0, 1,   0,   0,   0);   // black
        add_row(  0,   0, 100, 1, 255, 255, 255);   // white
        add_row(  0,   0,  50, 1, 127, 127, 127);   // mid grey, 127.5 truncated
        add_row(  0, 100,  50, 1, 255,   0,   0);   // pure primaries and secondaries
        add_row( 60, 100,  50, 1, 255, 255,   0);
        add_row(120, 100,  50, 1,   0, 255,   0);
        add_row(180, 100,  50, 1,   0, 255, 255);
        add_row(240, 100,  50, 1,   0,   0, 255);
        add_row(300, 100,  50, 1, 255,   0, 255);
        add_row(359, 100,  50, 0,   0,   0,   0);   // last degree of the circle
        add_row( 30, 100,  50, 0,   0,   0,   0);   // middle of each sector
        add_row( 90, 100,  50, 0,   0,   0,   0);
        add_row(150, 100,  50, 0,   0,   0,   0);
        add_row(210, 100,  50, 0,   0,   0,   0);
        add_row(270, 100,  50, 0,   0,   0,   0);
        add_row(330, 100,  50, 0,   0,   0,   0);
        add_row(360, 100,  50, 1, 255,   0,   0);   // hue wraps back to red
        add_row(511, 100,  50, 0,   0,   0,   0);   // largest hue, wraps to 151
        add_row(  0, 127,  50, 1, 255,   0,   0);   // saturation clamps to 100
        add_row(200,  60, 127, 1, 255, 255, 255);   // lightness clamps to 100
        add_row(511, 127, 127, 1, 255, 255, 255);   // every input bit high
        add_row( 45, 100,  25, 0,   0,   0,   0);
        add_row(300,  73,  81, 0,   0,   0,   0);
        add_row(100,   1,  99, 0,   0,   0,   0);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (pixel_table[i]) begin
            send_pixel(pixel_table[i].px,
                       pixel_table[i].known ? pixel_table[i].rgb : hsl_colour(pixel_table[i].px));
            directed_count++;
        end

        // Random part in chunks, each with its own idling mode
        for (int chunk = 0; chunk * CHUNK < RANDOM_PIXELS; chunk++) begin
            unique case (chunk % 4)
                0: begin src_max_gap = MAX_IDLE; snk_max_stall = MAX_IDLE; end
                1: begin src_max_gap = 0;        snk_max_stall = MAX_IDLE; end
                2: begin src_max_gap = MAX_IDLE; snk_max_stall = 0;        end
                default: begin src_max_gap = 0;  snk_max_stall = 0;        end
            endcase
            // back-pressure: receiver holds off while the sender keeps streaming
            if (chunk == 5 || chunk == 13) begin
                src_max_gap  = 0;
                hold_request = 1'b1;
            end
            repeat (CHUNK) send_random_pixel();
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (colour_q.size() != 0) @(posedge aclk);
        // catch any stray beat behind the last one
        for (drain = 0; drain < 4 * LATENCY; drain++) @(posedge aclk);

        $display("covered %0d directed and %0d random pixels, %0d with fields out of range",
                 directed_count, random_count, odd_fields);
        $display("%0d colours checked, receiver hold-off up to %0d cycles, %0d input refusals",
                 colours_seen, longest_hold, input_refusals);
        if (errors == 0)
            $display("tb_hsl_to_rgb_converter: done, clean");
        else
            $display("tb_hsl_to_rgb_converter: done, errors");
        $finish;
    end

endmodule

// ===== hsl_to_rgb_converter.f =====
hdl/hsl2rgb_pkg.sv
hdl/hsl2rgb_front.sv
hdl/hsl2rgb_back.sv
hdl/hsl_to_rgb_converter.sv
dv/tb_hsl_to_rgb_converter.sv
